[sv/mandelbrot_escape_time_pixel_top_assert.svh]
// Assertion macros used by the iteration engine of the escape-time pixel evaluator.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define MBROT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define MBROT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mbrot_pkg.sv]
// Shared constants, types and helper functions of the escape-time pixel evaluator.
package mbrot_pkg;

  localparam int COORD_BITS = 48;
  localparam int FRAC_BITS  = 44;
  localparam int COUNT_BITS = 16;
  localparam int PIXEL_BITS = 12;

  localparam int ZOOM_BITS     = COORD_BITS - 1;
  localparam int SIZE_BITS     = PIXEL_BITS + 1;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = COORD_BITS;

  localparam int IN_DATA_W  = ((2 * PIXEL_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((COUNT_BITS + 7) / 8) * 8;

  // point mapping: signed span times pitch, halved, plus center
  localparam int SPAN_W     = PIXEL_BITS + 2;
  localparam int MAP_PROD_W = SPAN_W + COORD_BITS;
  localparam int MAP_SUM_W  = MAP_PROD_W + 1;

  // iteration datapath
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIFF_W = SQ_W + 1;
  localparam int UPD_W  = DIFF_W - FRAC_BITS + 2;
  localparam int SAT_IN_W = (MAP_SUM_W > UPD_W) ? MAP_SUM_W : UPD_W;
  localparam int LO_W   = COORD_BITS / 2;
  localparam int HI_W   = COORD_BITS - LO_W;
  localparam int PP_W   = COORD_BITS + HI_W;
  localparam int ESC_POS = 2 * FRAC_BITS + 2;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [ZOOM_BITS-1:0]  ZOOM_RST  = ZOOM_BITS'(64'd17592186044);
  localparam logic [SIZE_BITS-1:0]  WIDTH_RST = SIZE_BITS'(1024);
  localparam logic [SIZE_BITS-1:0]  HEIGHT_RST = SIZE_BITS'(1024);
  localparam logic [COUNT_BITS-1:0] LIMIT_RST = COUNT_BITS'(256);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_ZOOM_STEP       = 3'd0,
    CFG_CENTER_REAL     = 3'd1,
    CFG_CENTER_IMAG     = 3'd2,
    CFG_FRAME_COLS      = 3'd3,
    CFG_FRAME_ROWS      = 3'd4,
    CFG_ITERATION_LIMIT = 3'd5
  } cfg_reg_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t cr;
    coord_t ci;
  } point_t;

  typedef struct packed {
    logic [ZOOM_BITS-1:0]  zoom_step;
    coord_t                center_real;
    coord_t                center_imag;
    logic [SIZE_BITS-1:0]  frame_cols;
    logic [SIZE_BITS-1:0]  frame_rows;
    logic [COUNT_BITS-1:0] iteration_limit;
  } cfg_t;

  // Clamp a wide signed value to the coordinate range.
  function automatic coord_t sat_coord(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-COORD_BITS:0] top;
    coord_t res;
    top = v[SAT_IN_W-1:COORD_BITS-1];
    if ((&top) || !(|top)) begin
      res = v[COORD_BITS-1:0];
    end else if (v[SAT_IN_W-1]) begin
      res = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return res;
  endfunction

  // Magnitude; the most negative coordinate maps to 2^(COORD_BITS-1).
  function automatic logic [COORD_BITS-1:0] mag_coord(input coord_t v);
    logic [COORD_BITS-1:0] u;
    u = v;
    return v[COORD_BITS-1] ? (~u + COORD_BITS'(1)) : u;
  endfunction

endpackage

[sv/mbrot_front.sv]
// Front end: maps a pixel position to its point c in the complex plane.
module mbrot_front
  import mbrot_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIXEL_BITS-1:0] in_col_i,
  input  logic [PIXEL_BITS-1:0] in_row_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output point_t                out_point_o
);

  logic                         pvalid_q, pvalid_d;
  logic signed [MAP_PROD_W-1:0] prod_x_q, prod_y_q;
  logic signed [SPAN_W-1:0]     span_x, span_y;
  logic signed [MAP_PROD_W-1:0] prod_x, prod_y;
  logic signed [SAT_IN_W-1:0]   sum_x, sum_y;
  logic                         load;

  // span = 2*index - size, always inside SPAN_W signed bits
  assign span_x = SPAN_W'({1'b0, in_col_i, 1'b0} - {1'b0, cfg_i.frame_cols});
  assign span_y = SPAN_W'({1'b0, in_row_i, 1'b0} - {1'b0, cfg_i.frame_rows});

  assign prod_x = span_x * $signed({1'b0, cfg_i.zoom_step});
  assign prod_y = span_y * $signed({1'b0, cfg_i.zoom_step});

  assign in_ready_o = !pvalid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    pvalid_d = pvalid_q;
    if (load) begin
      pvalid_d = 1'b1;
    end else if (out_ready_i) begin
      pvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else begin
      pvalid_q <= pvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prod_x_q <= prod_x;
      prod_y_q <= prod_y;
    end
  end

  // floor(product / 2) + center, clamped
  assign sum_x = SAT_IN_W'(prod_x_q >>> 1) + SAT_IN_W'(cfg_i.center_real);
  assign sum_y = SAT_IN_W'(prod_y_q >>> 1) + SAT_IN_W'(cfg_i.center_imag);

  assign out_valid_o    = pvalid_q;
  assign out_point_o.cr = sat_coord(sum_x);
  assign out_point_o.ci = sat_coord(sum_y);

endmodule

[sv/mbrot_fifo.sv]
// Short queue of mapped points between the front end and the iteration engine.
module mbrot_fifo
  import mbrot_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  point_t push_data_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output point_t pop_data_o
);

  point_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  push, pop;

  assign push_ready_o = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/mbrot_back.sv]
// Iteration engine: runs z <- z^2 + c until escape or the limit, holds the result word.
`include "mandelbrot_escape_time_pixel_top_assert.svh"

module mbrot_back
  import mbrot_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  point_t                pop_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COUNT_BITS-1:0] out_count_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL_LO = 6'b000010,
    ST_MUL_HI = 6'b000100,
    ST_SUM    = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  localparam logic [SQ_W:0] ESC_BOUND = (SQ_W + 1)'(1) << ESC_POS;

  state_e                    state_q, state_d;
  logic                      out_valid_q, out_valid_d;
  logic [COUNT_BITS-1:0]     out_data_q;
  logic [COUNT_BITS-1:0]     k_q, k_d;
  coord_t                    cr_q, ci_q;
  logic [COORD_BITS-1:0]     mr_q, mr_d, mi_q, mi_d;
  logic                      sx_q, sx_d;
  logic [SQ_W-1:0]           r2_q, r2_d, i2_q, i2_d, x2_q, x2_d;
  logic signed [DIFF_W-1:0]  diff_q, xs_q;
  logic signed [DIFF_W-1:0]  diff_d, xs_d;

  logic [HI_W-1:0]           br, bi;
  logic [PP_W-1:0]           pp_r, pp_i, pp_x;
  logic [SQ_W:0]             mag_sum;
  logic                      escape;
  logic signed [SAT_IN_W-1:0] nr_sum, ni_sum;
  coord_t                    zr_new, zi_new;
  logic                      last_iter;
  logic                      pop, out_free, load_out;

  assign pop      = (state_q == ST_IDLE) && pop_valid_i;
  assign out_free = !out_valid_q || out_ready_i;
  assign load_out = (state_q == ST_DONE) && out_free;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_count_o = out_data_q;

  // Three 48x24 multipliers; each product takes a low and a high pass.
  assign br   = (state_q == ST_MUL_HI) ? HI_W'(mr_q[COORD_BITS-1:LO_W]) : HI_W'(mr_q[LO_W-1:0]);
  assign bi   = (state_q == ST_MUL_HI) ? HI_W'(mi_q[COORD_BITS-1:LO_W]) : HI_W'(mi_q[LO_W-1:0]);
  assign pp_r = mr_q * br;
  assign pp_i = mi_q * bi;
  assign pp_x = mr_q * bi;

  assign mag_sum = {1'b0, r2_q} + {1'b0, i2_q};
  assign escape  = (mag_sum > ESC_BOUND);

  assign nr_sum = SAT_IN_W'($signed(diff_q[DIFF_W-1:FRAC_BITS])) + SAT_IN_W'(cr_q);
  assign ni_sum = SAT_IN_W'($signed(xs_q[DIFF_W-1:FRAC_BITS-1])) + SAT_IN_W'(ci_q);
  assign zr_new = sat_coord(nr_sum);
  assign zi_new = sat_coord(ni_sum);

  assign last_iter = (k_q == cfg_i.iteration_limit - COUNT_BITS'(1));

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    k_d         = k_q;
    mr_d        = mr_q;
    mi_d        = mi_q;
    sx_d        = sx_q;
    r2_d        = r2_q;
    i2_d        = i2_q;
    x2_d        = x2_q;
    diff_d      = diff_q;
    xs_d        = xs_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          mr_d = mag_coord(pop_data_i.cr);
          mi_d = mag_coord(pop_data_i.ci);
          sx_d = pop_data_i.cr[COORD_BITS-1] ^ pop_data_i.ci[COORD_BITS-1];
          if (cfg_i.iteration_limit == '0) begin
            // no test at all: limit - 1 wraps to all ones
            k_d     = '1;
            state_d = ST_DONE;
          end else begin
            k_d     = '0;
            state_d = ST_MUL_LO;
          end
        end
      end
      ST_MUL_LO: begin
        r2_d    = SQ_W'(pp_r);
        i2_d    = SQ_W'(pp_i);
        x2_d    = SQ_W'(pp_x);
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        r2_d    = r2_q + (SQ_W'(pp_r) << LO_W);
        i2_d    = i2_q + (SQ_W'(pp_i) << LO_W);
        x2_d    = x2_q + (SQ_W'(pp_x) << LO_W);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        diff_d = $signed({1'b0, r2_q}) - $signed({1'b0, i2_q});
        xs_d   = sx_q ? $signed(DIFF_W'(0) - {1'b0, x2_q}) : $signed({1'b0, x2_q});
        state_d = escape ? ST_DONE : ST_UPDATE;
      end
      ST_UPDATE: begin
        mr_d = mag_coord(zr_new);
        mi_d = mag_coord(zi_new);
        sx_d = zr_new[COORD_BITS-1] ^ zi_new[COORD_BITS-1];
        if (last_iter) begin
          state_d = ST_DONE;
        end else begin
          k_d     = k_q + COUNT_BITS'(1);
          state_d = ST_MUL_LO;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cr_q <= pop_data_i.cr;
      ci_q <= pop_data_i.ci;
    end
    if (load_out) begin
      out_data_q <= k_q;
    end
    k_q    <= k_d;
    mr_q   <= mr_d;
    mi_q   <= mi_d;
    sx_q   <= sx_d;
    r2_q   <= r2_d;
    i2_q   <= i2_d;
    x2_q   <= x2_d;
    diff_q <= diff_d;
    xs_q   <= xs_d;
  end

  `MBROT_ASSERT_NXT(a_out_only_from_done, (state_q != ST_DONE) && !out_valid_q, !out_valid_q, "result word without a finished point")
  `MBROT_ASSERT_NXT(a_mul_passes_in_order, state_q == ST_MUL_LO, state_q == ST_MUL_HI, "multiply passes out of order")
  `MBROT_ASSERT_NXT(a_load_starts_at_zero, (state_q == ST_IDLE) && pop_valid_i && (cfg_i.iteration_limit != '0), (state_q == ST_MUL_LO) && (k_q == '0), "point load did not start at iteration zero")

endmodule

[sv/mandelbrot_escape_time_pixel_top.sv]
// Top level of the escape-time pixel evaluator: config registers, front end, queue, engine.
// Each input word names a pixel (column in the low 12 bits, row above); the front end maps it
// to c = center + floor((2*index - size) * zoom_step / 2), clamped to signed Q4.44, through
// one register stage, from which the point enters the queue once the queue has room.
// The front can hold up to three points ahead of the engine (one in its register, two in the
// queue) before it stalls the input. The engine then iterates
// z <- z^2 + c from z = c and returns the first iteration whose |z|^2 exceeds 4, or
// iteration_limit - 1. Each iteration steps through the states MUL_LO and MUL_HI, in which
// the three shared 48x24 multipliers form zr^2, zi^2 and zr*zi in a low and a high pass,
// then SUM, which tests for escape, and UPDATE; an escaping item leaves from SUM. A finished
// result waits in the output register while the next point is already being iterated.
// Configuration must be written by the user only while idle; the block does not enforce it.
module mandelbrot_escape_time_pixel_top
  import mbrot_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_W-1:0]     s_axis_tdata,   // pixel_col, pixel_row
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_W-1:0]    m_axis_tdata    // escape_count
);

  cfg_t                  cfg_q;
  logic                  fr_valid, fr_ready;
  point_t                fr_point;
  logic                  q_valid, q_ready;
  point_t                q_point;
  logic [COUNT_BITS-1:0] count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom_step       <= ZOOM_RST;
      cfg_q.center_real     <= '0;
      cfg_q.center_imag     <= '0;
      cfg_q.frame_cols      <= WIDTH_RST;
      cfg_q.frame_rows      <= HEIGHT_RST;
      cfg_q.iteration_limit <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_ZOOM_STEP:       cfg_q.zoom_step       <= cfg_wdata_i[ZOOM_BITS-1:0];
        CFG_CENTER_REAL:     cfg_q.center_real     <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_CENTER_IMAG:     cfg_q.center_imag     <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_FRAME_COLS:      cfg_q.frame_cols      <= cfg_wdata_i[SIZE_BITS-1:0];
        CFG_FRAME_ROWS:      cfg_q.frame_rows      <= cfg_wdata_i[SIZE_BITS-1:0];
        CFG_ITERATION_LIMIT: cfg_q.iteration_limit <= cfg_wdata_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  mbrot_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_col_i    (s_axis_tdata[PIXEL_BITS-1:0]),
    .in_row_i    (s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_point_o (fr_point)
  );

  mbrot_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_point),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_point)
  );

  mbrot_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (q_valid),
    .pop_ready_o (q_ready),
    .pop_data_i  (q_point),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_count_o (count)
  );

  assign m_axis_tdata = OUT_DATA_W'(count);

endmodule
